@@ sv/lmts_pkg.sv @@
// ----------------------------------------------------------------------------
// lmts_pkg: shared types and constants of the LCD mode timing sequencer
// Mode codes, mode lengths in dots, line limits and the state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmts_pkg;

  // Frame geometry
  localparam int unsigned VISIBLE_LINES = 144;
  localparam int unsigned TOTAL_LINES   = 154;

  localparam int unsigned DOT_W  = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned MCYC_W = 3;
  localparam int unsigned MODE_W = 2;

  localparam logic [LINE_W-1:0] VISIBLE_LINE_C = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] TOTAL_LINE_C   = LINE_W'(TOTAL_LINES);

  // Mode lengths in dots
  localparam logic [DOT_W-1:0] HBLANK_DOTS      = 9'd204;
  localparam logic [DOT_W-1:0] VBLANK_LINE_DOTS = 9'd456;
  localparam logic [DOT_W-1:0] OAM_DOTS         = 9'd80;
  localparam logic [DOT_W-1:0] TRANSFER_DOTS    = 9'd172;
  localparam logic [DOT_W-1:0] DOT_MAX          = 9'h1FF;

  // LCD mode codes as shown on the result channel
  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes
  localparam logic REG_DISPLAY_ENABLED = 1'b0;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_XFER   = 4'b1000
  } lcd_state_t;

  typedef struct packed {
    lcd_state_t        mode;
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line;
  } timing_t;

  typedef struct packed {
    logic line_render;
    logic vblank_start;
    logic clear_screen;
  } strobe_t;

  function automatic logic [MODE_W-1:0] mode_code(input lcd_state_t st);
    logic [MODE_W-1:0] code;
    unique case (st)
      ST_HBLANK: code = MODE_HBLANK;
      ST_VBLANK: code = MODE_VBLANK;
      ST_OAM:    code = MODE_OAM;
      ST_XFER:   code = MODE_TRANSFER;
      default:   code = MODE_OAM;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ sv/lmts_if.sv @@
// ----------------------------------------------------------------------------
// lmts_in_if / lmts_out_if: valid-ready channels of the sequencer
// Input channel carries elapsed machine cycles; result channel the LCD status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lmts_in_if;
  logic                        valid;
  logic                        ready;
  logic [lmts_pkg::MCYC_W-1:0] elapsed_mcycles;

  modport source (output valid, output elapsed_mcycles, input ready);
  modport sink   (input valid, input elapsed_mcycles, output ready);
endinterface

interface lmts_out_if;
  logic                        valid;
  logic                        ready;
  logic [lmts_pkg::MODE_W-1:0] lcd_mode;
  logic [lmts_pkg::LINE_W-1:0] current_line;
  logic                        line_render;
  logic                        vblank_start;
  logic                        clear_screen;

  modport source (output valid, output lcd_mode, output current_line,
                  output line_render, output vblank_start, output clear_screen,
                  input ready);
  modport sink   (input valid, input lcd_mode, input current_line,
                  input line_render, input vblank_start, input clear_screen,
                  output ready);
endinterface

`default_nettype wire

@@ sv/lmts_cfg.sv @@
// ----------------------------------------------------------------------------
// lmts_cfg: APB register block
// Holds the display enable bit; writes above index 0 are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmts_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             display_enabled
);

  logic disp_en_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lmts_pkg::REG_DISPLAY_ENABLED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_en_r <= 1'b1;
    end else if (wr_en) begin
      disp_en_r <= pwdata[0];
    end
  end

  // Read mux; pad the single bit register
  always_comb begin
    if (paddr[2] == lmts_pkg::REG_DISPLAY_ENABLED) begin
      prdata = {31'd0, disp_en_r};
    end else begin
      prdata = 32'd0;
    end
  end

  assign display_enabled = disp_en_r;

endmodule

`default_nettype wire

@@ sv/lmts_step.sv @@
// ----------------------------------------------------------------------------
// lmts_step: next-state logic of the mode sequencer
// Add dots, check the current mode's length, advance mode and line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmts_step (
  input  wire lmts_pkg::timing_t      cur,
  input  wire logic [lmts_pkg::MCYC_W-1:0] mcycles,
  input  wire logic                   display_enabled,
  output lmts_pkg::timing_t           nxt,
  output lmts_pkg::strobe_t           strb
);

  logic [lmts_pkg::DOT_W:0]    sum;
  logic [lmts_pkg::DOT_W-1:0]  dots;
  logic [lmts_pkg::LINE_W-1:0] line_inc;

  always_comb begin
    // Four dots per machine cycle; hold at the counter maximum
    sum      = {1'b0, cur.dots} + {5'd0, mcycles, 2'b00};
    dots     = sum[lmts_pkg::DOT_W] ? lmts_pkg::DOT_MAX : sum[lmts_pkg::DOT_W-1:0];
    line_inc = cur.line + 8'd1;

    nxt      = cur;
    nxt.dots = dots;
    strb     = '0;

    unique case (cur.mode)
      lmts_pkg::ST_HBLANK: begin
        if (dots >= lmts_pkg::HBLANK_DOTS) begin
          nxt.dots = '0;
          nxt.line = line_inc;
          if (line_inc == lmts_pkg::VISIBLE_LINE_C) begin
            nxt.mode          = lmts_pkg::ST_VBLANK;
            strb.vblank_start = 1'b1;
            strb.clear_screen = !display_enabled;
          end else begin
            nxt.mode = lmts_pkg::ST_OAM;
          end
        end
      end
      lmts_pkg::ST_VBLANK: begin
        if (dots >= lmts_pkg::VBLANK_LINE_DOTS) begin
          nxt.dots = '0;
          nxt.line = line_inc;
          if (line_inc >= lmts_pkg::TOTAL_LINE_C) begin
            nxt.mode = lmts_pkg::ST_OAM;
            nxt.line = '0;
          end
        end
      end
      lmts_pkg::ST_OAM: begin
        if (dots >= lmts_pkg::OAM_DOTS) begin
          nxt.dots = '0;
          nxt.mode = lmts_pkg::ST_XFER;
        end
      end
      lmts_pkg::ST_XFER: begin
        if (dots >= lmts_pkg::TRANSFER_DOTS) begin
          nxt.dots         = '0;
          nxt.mode         = lmts_pkg::ST_HBLANK;
          strb.line_render = display_enabled;
        end
      end
      default: begin
        nxt.mode = lmts_pkg::ST_OAM;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/lcd_mode_timing_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer: LCD mode and scanline timing
// Counts dots from elapsed machine cycles and steps through OAM search,
// pixel transfer, horizontal blank and vertical blank lines.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake        | payload
//   ----------+-----------+------------------+-----------------------------------
//   in_chan   | sink      | valid / ready    | elapsed_mcycles
//   out_chan  | source    | valid / ready    | lcd_mode, current_line, strobes
//   APB       | slave     | psel/penable     | display_enabled at byte address 0
//
// One item per cycle while the result channel does not stall; a result passes
// through the input register, then the result register, before it is
// offered on the result channel.
// The timing state (dots, mode, line) updates as an item leaves the input
// register, so each item sees what the previous one left.
// Synchronous active-low reset: mode OAM search, line 0, dots 0, display on.
// A stalled result holds the output register, which in turn holds the input
// register; ready drops only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_mode_timing_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lmts_in_if.sink          in_chan,
  lmts_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Input register
  logic                        in_vld_r;
  logic [lmts_pkg::MCYC_W-1:0] in_mcyc_r;

  // Timing state
  lmts_pkg::timing_t tm_r;
  lmts_pkg::timing_t tm_nxt;
  lmts_pkg::strobe_t strb_nxt;

  // Result register
  logic                        out_vld_r;
  logic [lmts_pkg::MODE_W-1:0] out_mode_r;
  logic [lmts_pkg::LINE_W-1:0] out_line_r;
  lmts_pkg::strobe_t           out_strb_r;

  logic display_enabled;
  logic out_free;
  logic in_take;
  logic step_en;

  lmts_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .display_enabled (display_enabled)
  );

  lmts_step u_step (
    .cur             (tm_r),
    .mcycles         (in_mcyc_r),
    .display_enabled (display_enabled),
    .nxt             (tm_nxt),
    .strb            (strb_nxt)
  );

  // Advance the pipe whenever the result register is empty or being drained
  assign out_free      = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign step_en       = in_vld_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  // Payload register; no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mcyc_r <= in_chan.elapsed_mcycles;
    end
  end

  // Commit the timing state only when the item moves on to the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_r.mode <= lmts_pkg::ST_OAM;
      tm_r.dots <= '0;
      tm_r.line <= '0;
    end else if (step_en) begin
      tm_r <= tm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_mode_r <= lmts_pkg::mode_code(tm_nxt.mode);
      out_line_r <= tm_nxt.line;
      out_strb_r <= strb_nxt;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.lcd_mode     = out_mode_r;
  assign out_chan.current_line = out_line_r;
  assign out_chan.line_render  = out_strb_r.line_render;
  assign out_chan.vblank_start = out_strb_r.vblank_start;
  assign out_chan.clear_screen = out_strb_r.clear_screen;

endmodule

`default_nettype wire

@@ sv/lmts_checker.sv @@
// ----------------------------------------------------------------------------
// lmts_checker: port-level checks of the sequencer
// Relates strobes, mode and line on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmts_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lmts_pkg::MODE_W-1:0] lcd_mode,
  input wire logic [lmts_pkg::LINE_W-1:0] current_line,
  input wire logic                        line_render,
  input wire logic                        vblank_start,
  input wire logic                        clear_screen
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lcd_mode) && $stable(current_line))
    else $error("result changed while stalled");

  // Enter vblank only on the first invisible line
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && vblank_start |->
      lcd_mode == lmts_pkg::MODE_VBLANK && current_line == lmts_pkg::VISIBLE_LINE_C)
    else $error("vblank start outside vblank entry");

  // Render a line only as hblank begins
  a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_render |-> lcd_mode == lmts_pkg::MODE_HBLANK && !vblank_start)
    else $error("line render outside hblank entry");

  // Clear the screen only at vblank entry
  a_clear_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clear_screen |-> vblank_start)
    else $error("screen clear without vblank entry");

  // Keep visible modes on visible lines
  a_visible_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lcd_mode != lmts_pkg::MODE_VBLANK |->
      current_line < lmts_pkg::VISIBLE_LINE_C)
    else $error("visible mode on a blank line");

endmodule

bind lcd_mode_timing_sequencer lmts_checker u_lmts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .lcd_mode     (out_chan.lcd_mode),
  .current_line (out_chan.current_line),
  .line_render  (out_chan.line_render),
  .vblank_start (out_chan.vblank_start),
  .clear_screen (out_chan.clear_screen)
);

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lcd_mode_timing_sequencer
// Drives elapsed machine cycles over the input channel and predicts each
// status result (mode, line and the three strobes) in a scoreboard. It writes
// the display enable register over APB between phases, varies idling on both
// channels and holds the result channel off long enough to stall the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Register map: byte addresses, one register per 4 bytes
  localparam int          REG_UNMAPPED         = 1;
  localparam logic [2:0]  ADDR_DISPLAY_ENABLED =
    3'(4 * int'(lmts_pkg::REG_DISPLAY_ENABLED));
  localparam logic [2:0]  ADDR_UNMAPPED        = 3'(4 * REG_UNMAPPED);

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_STEPS  = 340;

  typedef logic [lmts_pkg::MCYC_W-1:0] mcyc_t;

  typedef struct packed {
    logic [lmts_pkg::MODE_W-1:0] lcd_mode;
    logic [lmts_pkg::LINE_W-1:0] current_line;
    logic                        line_render;
    logic                        vblank_start;
    logic                        clear_screen;
  } lcd_status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the timing state, one expected status per transfer
  // --------------------------------------------------------------------------
  class lcd_timing_scoreboard;
    lcd_status_t                 expected_status[$];
    logic                        display_on;
    logic [lmts_pkg::DOT_W-1:0]  dot_count;
    logic [lmts_pkg::MODE_W-1:0] mode;
    logic [lmts_pkg::LINE_W-1:0] line;
    int                          errors;

    function new();
      display_on = 1'b1;
      dot_count  = '0;
      mode       = lmts_pkg::MODE_OAM;
      line       = '0;
      errors     = 0;
    endfunction

    function void set_display(logic on);
      display_on = on;
    endfunction

    function int pending_count();
      return expected_status.size();
    endfunction

    // Advance the timing by one step and queue the status it leaves behind
    function void note_step(mcyc_t mcycles);
      logic [lmts_pkg::DOT_W:0] sum;
      lcd_status_t              st;
      st  = '0;
      sum = {1'b0, dot_count} + ((lmts_pkg::DOT_W+1)'(mcycles) << 2);
      dot_count = (sum > {1'b0, lmts_pkg::DOT_MAX}) ? lmts_pkg::DOT_MAX
                                                     : sum[lmts_pkg::DOT_W-1:0];
      case (mode)
        lmts_pkg::MODE_HBLANK: begin
          if (dot_count >= lmts_pkg::HBLANK_DOTS) begin
            dot_count = '0;
            line      = line + 1'b1;
            if (line == lmts_pkg::VISIBLE_LINE_C) begin
              mode            = lmts_pkg::MODE_VBLANK;
              st.vblank_start = 1'b1;
              st.clear_screen = !display_on;
            end else begin
              mode = lmts_pkg::MODE_OAM;
            end
          end
        end
        lmts_pkg::MODE_VBLANK: begin
          if (dot_count >= lmts_pkg::VBLANK_LINE_DOTS) begin
            dot_count = '0;
            line      = line + 1'b1;
            if (line >= lmts_pkg::TOTAL_LINE_C) begin
              mode = lmts_pkg::MODE_OAM;
              line = '0;
            end
          end
        end
        lmts_pkg::MODE_OAM: begin
          if (dot_count >= lmts_pkg::OAM_DOTS) begin
            dot_count = '0;
            mode      = lmts_pkg::MODE_TRANSFER;
          end
        end
        default: begin
          if (dot_count >= lmts_pkg::TRANSFER_DOTS) begin
            dot_count      = '0;
            mode           = lmts_pkg::MODE_HBLANK;
            st.line_render = display_on;
          end
        end
      endcase
      st.lcd_mode     = mode;
      st.current_line = line;
      expected_status.push_back(st);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(lcd_status_t got);
      lcd_status_t want;
      if (expected_status.size() == 0) begin
        $error("status transfer with nothing expected: mode %0d line %0d",
               got.lcd_mode, got.current_line);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("lcd_mode",     want.lcd_mode,     got.lcd_mode);
      compare_field("current_line", want.current_line, got.current_line);
      compare_field("line_render",  want.line_render,  got.line_render);
      compare_field("vblank_start", want.vblank_start, got.vblank_start);
      compare_field("clear_screen", want.clear_screen, got.clear_screen);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, APB and the block itself
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lmts_in_if  in_ch ();
  lmts_out_if out_ch ();

  lcd_mode_timing_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lcd_timing_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int cycle_count   = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lcd_mode_timing_sequencer] ERROR");
      $finish;
    end
  end

  // Sample every status transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_status(lcd_status_t'{lcd_mode:     out_ch.lcd_mode,
                                    current_line: out_ch.current_line,
                                    line_render:  out_ch.line_render,
                                    vblank_start: out_ch.vblank_start,
                                    clear_screen: out_ch.clear_screen});
    end
  end

  // Receiver: random back-pressure, or a long hold-off when asked for one.
  // During the hold the sender keeps offering, so the block fills and stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one step, idling first at random; note it once the transfer happens
  task automatic send_step(input mcyc_t mcycles);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.elapsed_mcycles <= mcycles;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_step(mcycles);
  endtask

  task automatic end_steps();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // APB write: setup cycle, then access until pready; mirror it in the predictor
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DISPLAY_ENABLED) sb.set_display(data[0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every status has come back, then allow for the pipeline
  task automatic settle();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Bias towards long steps so that mode changes come often
  function automatic mcyc_t pick_mcycles();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)      return mcyc_t'(7);
    else if (roll < 75) return mcyc_t'($urandom_range(6, 4));
    else                return mcyc_t'($urandom_range(7));
  endfunction

  // A fixed number of random steps
  task automatic run_random(input int n_steps);
    for (int i = 0; i < n_steps; i++) begin
      send_step(pick_mcycles());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    mcyc_t directed_steps[$];
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.elapsed_mcycles = '0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Display on; a write to the unmapped index must leave it on
    apb_write(ADDR_DISPLAY_ENABLED, 32'h0000_0001);
    apb_write(ADDR_UNMAPPED, 32'h0000_0000);

    // Directed: a zero step, then OAM search, pixel transfer and hblank each
    // ended exactly on their length, then OAM overrun to drop leftover dots
    directed_steps = '{3'd0, 3'd7, 3'd7, 3'd6,
                       3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd1,
                       3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd1, 3'd0, 3'd1,
                       3'd7, 3'd7, 3'd7, 3'd5};
    send_idle_pct = 35;
    recv_idle_pct = 66;
    foreach (directed_steps[i]) send_step(directed_steps[i]);
    end_steps();
    settle();

    // Phase 0: display off, sender idles lightly, receiver heavily
    apb_write(ADDR_DISPLAY_ENABLED, 32'hFFFF_FFFE);
    send_idle_pct = 35;
    recv_idle_pct = 66;
    run_random(PHASE_STEPS);
    end_steps();
    settle();

    // Phase 1: display on, idling the other way round
    apb_write(ADDR_UNMAPPED, 32'h0000_0000);
    apb_write(ADDR_DISPLAY_ENABLED, 32'h8000_0001);
    send_idle_pct = 66;
    recv_idle_pct = 35;
    run_random(PHASE_STEPS);
    end_steps();
    settle();

    // Phase 2: random display setting, no idling, one long receiver hold-off
    apb_write(ADDR_DISPLAY_ENABLED, 32'($urandom_range(1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_random(PHASE_STEPS);
    end_steps();

    settle();
    if (sb.pending_count() != 0) begin
      $error("%0d status results never arrived", sb.pending_count());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[lcd_mode_timing_sequencer] OK");
    end else begin
      $display("[lcd_mode_timing_sequencer] ERROR");
    end
    $finish;
  end

endmodule

@@ lcd_mode_timing_sequencer.f @@
sv/lmts_pkg.sv
sv/lmts_if.sv
sv/lmts_cfg.sv
sv/lmts_step.sv
sv/lcd_mode_timing_sequencer.sv
sv/lmts_checker.sv
bench/testbench.sv
